/* design/btq_pkg.sv */
// ----------------------------------------------------------------------------
// btq_pkg
// Shared types, constants and the 5x7 glyph ROM of the bitmap text quad
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package btq_pkg;

	// Glyph geometry
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
	localparam int GLYPH_IDX_W = 6;

	// Datapath widths
	localparam int COORD_W = 16;
	localparam int SCALE_W = 6;            // font_size / 7 is at most 36
	localparam int ORIGIN_W = 14;
	localparam int FONT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;
	localparam int QUAD_COUNT_BITS = 20;
	localparam int QUAD_NUMBER_W = 20;

	// Divide by 7 through a reciprocal: exact for every 8-bit font size
	localparam int RECIP7_MUL = 293;
	localparam int RECIP7_SHIFT = 11;
	localparam int RECIP7_PROD_W = 17;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd2;

	// Input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_CHAR = 1'b1;

	// Character codes
	localparam logic [15:0] CODE_NEWLINE = 16'h000A;
	localparam logic [15:0] CODE_DIGIT_0 = 16'h0030;
	localparam logic [15:0] CODE_DIGIT_9 = 16'h0039;
	localparam logic [15:0] CODE_UPPER_A = 16'h0041;
	localparam logic [15:0] CODE_UPPER_Z = 16'h005A;
	localparam logic [15:0] CODE_LOWER_A = 16'h0061;
	localparam logic [15:0] CODE_LOWER_Z = 16'h007A;
	localparam logic [15:0] CASE_OFFSET = 16'h0020;
	localparam logic [GLYPH_IDX_W-1:0] DIGIT_BASE = 6'd26;

	// One emitted block
	typedef struct packed {
		logic signed [COORD_W-1:0] left_px;
		logic signed [COORD_W-1:0] top_px;
		logic signed [COORD_W-1:0] right_px;
		logic signed [COORD_W-1:0] bottom_px;
		logic [QUAD_NUMBER_W-1:0] quad_number;
		logic last_of_char;
	} quad_t;

	// Scanner status toward the top level
	typedef struct packed {
		logic busy;
		logic emit;
		logic done;
	} scan_evt_t;

	// Result of the character lookup
	typedef struct packed {
		logic hit;
		logic [GLYPH_IDX_W-1:0] idx;
	} glyph_sel_t;

	// Pixel scale: max(1, font_size / 7)
	function automatic logic [SCALE_W-1:0] scale_of(input logic [FONT_W-1:0] fs);
		logic [RECIP7_PROD_W-1:0] prod;
		logic [SCALE_W-1:0] q;
		prod = RECIP7_PROD_W'(fs) * RECIP7_PROD_W'(RECIP7_MUL);
		q = prod[RECIP7_SHIFT +: SCALE_W];
		return (q == '0) ? SCALE_W'(1) : q;
	endfunction

	// Code to glyph index; lower case folds to upper case
	function automatic glyph_sel_t glyph_lookup(input logic [15:0] code);
		glyph_sel_t sel;
		logic [15:0] c;
		sel = '0;
		c = code;
		if (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) begin
			c = c - CASE_OFFSET;
		end
		if (c >= CODE_UPPER_A && c <= CODE_UPPER_Z) begin
			sel.hit = 1'b1;
			sel.idx = GLYPH_IDX_W'(c - CODE_UPPER_A);
		end else if (c >= CODE_DIGIT_0 && c <= CODE_DIGIT_9) begin
			sel.hit = 1'b1;
			sel.idx = GLYPH_IDX_W'(c - CODE_DIGIT_0) + DIGIT_BASE;
		end
		return sel;
	endfunction

	// Glyph bitmap, top row in the MSBs, leftmost column first in each row
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
		logic [GLYPH_BITS-1:0] g;
		case (idx)
			6'd0:  g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			6'd1:  g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
			6'd2:  g = {5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F};
			6'd3:  g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
			6'd4:  g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
			6'd5:  g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
			6'd6:  g = {5'h0F,5'h10,5'h10,5'h17,5'h11,5'h11,5'h0F};
			6'd7:  g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			6'd8:  g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
			6'd9:  g = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
			6'd10: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			6'd11: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
			6'd12: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
			6'd13: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			6'd14: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			6'd15: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
			6'd16: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
			6'd17: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
			6'd18: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
			6'd19: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			6'd20: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			6'd21: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
			6'd22: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
			6'd23: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
			6'd24: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
			6'd25: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
			6'd26: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
			6'd27: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
			6'd28: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
			6'd29: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
			6'd30: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
			6'd31: g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
			6'd32: g = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
			6'd33: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			6'd34: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
			6'd35: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

/* design/btq_scan.sv */
// ----------------------------------------------------------------------------
// btq_scan, a bit-serial glyph scanner, shifts the 35 glyph bits out
// one per cycle up to the last lit bit, a lit bit waiting for a free output
// slot, and tracks the pixel position of the current bit incrementally.
// ----------------------------------------------------------------------------
`default_nettype none

module btq_scan
	import btq_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [GLYPH_BITS-1:0]      glyph,
	input  wire logic [COORD_W-1:0]         cursor_x,
	input  wire logic [COORD_W-1:0]         cursor_y,
	input  wire logic [SCALE_W-1:0]         scale,
	input  wire logic [QUAD_COUNT_BITS-1:0] count,
	input  wire logic                       slot_free,
	output scan_evt_t                       evt,
	output quad_t                           quad
);

	logic [GLYPH_BITS-1:0] bits_q;
	logic [2:0]            col_q;
	logic [COORD_W-1:0]    px_q;
	logic [COORD_W-1:0]    py_q;
	logic                  busy_q;

	logic                  cur_bit;
	logic                  rest_zero;
	logic                  step;
	logic [COORD_W-1:0]    scale_ext;

	assign cur_bit   = bits_q[GLYPH_BITS-1];
	assign rest_zero = (bits_q[GLYPH_BITS-2:0] == '0);
	assign scale_ext = COORD_W'(scale);

	// A dark bit always advances; a lit bit waits for a free output slot
	assign step = busy_q && (!cur_bit || slot_free);

	assign evt.busy = busy_q;
	assign evt.emit = step && cur_bit;
	assign evt.done = step && rest_zero;

	// Block built from the current position
	assign quad.left_px      = px_q;
	assign quad.top_px       = py_q;
	assign quad.right_px     = px_q + scale_ext;
	assign quad.bottom_px    = py_q + scale_ext;
	assign quad.quad_number  = QUAD_NUMBER_W'(count);
	assign quad.last_of_char = rest_zero;

	// Control: busy from load until the last lit bit is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (step && rest_zero) begin
			busy_q <= 1'b0;
		end
	end

	// Shift register and position tracking
	always_ff @(posedge clk) begin
		if (load) begin
			bits_q <= glyph;
			col_q  <= '0;
			px_q   <= cursor_x;
			py_q   <= cursor_y;
		end else if (step) begin
			bits_q <= {bits_q[GLYPH_BITS-2:0], 1'b0};
			if (col_q == 3'(GLYPH_COLS - 1)) begin
				col_q <= '0;
				px_q  <= cursor_x;
				py_q  <= py_q + scale_ext;
			end else begin
				col_q <= col_q + 3'd1;
				px_q  <= px_q + scale_ext;
			end
		end
	end

endmodule

`default_nettype wire

/* design/btq_out_reg.sv */
// ----------------------------------------------------------------------------
// btq_out_reg
// Output register for one block; takes a new block in the cycle the old
// one transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module btq_out_reg
	import btq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire quad_t quad_in,
	output logic       slot_free,
	output logic       valid,
	input  wire logic  ready,
	output quad_t      quad_out
);

	logic  valid_q;
	quad_t data_q;

	assign slot_free = !valid_q || ready;
	assign valid     = valid_q;
	assign quad_out  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= quad_in;
		end
	end

endmodule

`default_nettype wire

/* design/bitmap_text_quad_generator.sv */
// ----------------------------------------------------------------------------
// bitmap_text_quad_generator
// Character stream to filled pixel blocks through a 5x7 glyph ROM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): action 0 restarts the text at the
//   origin and clears the block count; action 1 carries char_code.
//   Output channel (out_valid/out_ready): one block per lit glyph bit, with
//   its edges, running quad_number and last_of_char on the final block.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 font_size,
//   1 origin_x, 2 origin_y; index 3 is ignored. Write only while idle.
// Scan:
//   Start, newline, space and unknown codes load nothing into the scanner.
//   A glyph is scanned one bit per cycle by a shift register, ending at its
//   last lit bit; a lit bit waits while the output register holds an untaken
//   block. The transfer loads the shift register; the first lit bit then moves
//   into the output register once the leading dark bits are shifted out.
// Reset: cursor at the origin (0,0), count zero, scale 2 (font_size 14).
// Stall: a lit bit waits while the output register holds an untaken block;
//   dark bits keep shifting. in_ready stays low until the scan completes.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_quad_generator
	import btq_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         action,
	input  wire logic [15:0]                  char_code,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_W-1:0]         left_px,
	output logic signed [COORD_W-1:0]         top_px,
	output logic signed [COORD_W-1:0]         right_px,
	output logic signed [COORD_W-1:0]         bottom_px,
	output logic [QUAD_NUMBER_W-1:0]          quad_number,
	output logic                              last_of_char,
	// configuration channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	logic [SCALE_W-1:0]         scale_q;
	logic [ORIGIN_W-1:0]        origin_x_q;
	logic [ORIGIN_W-1:0]        origin_y_q;
	logic [COORD_W-1:0]         cursor_x_q;
	logic [COORD_W-1:0]         cursor_y_q;
	logic [QUAD_COUNT_BITS-1:0] count_q;

	logic                       in_xfer;
	logic                       scan_load;
	glyph_sel_t                 sel;
	scan_evt_t                  evt;
	quad_t                      scan_quad;
	quad_t                      out_quad;
	logic                       slot_free;
	logic [COORD_W-1:0]         origin_x_ext;
	logic [COORD_W-1:0]         origin_y_ext;
	logic [COORD_W-1:0]         advance;
	logic [COORD_W-1:0]         line_step;

	assign cfg_ready = 1'b1;
	assign in_ready  = !evt.busy;
	assign in_xfer   = in_valid && in_ready;
	assign sel       = glyph_lookup(char_code);
	assign scan_load = in_xfer && (action == ACT_CHAR) && (char_code != CODE_NEWLINE) && sel.hit;

	assign origin_x_ext = {{(COORD_W-ORIGIN_W){origin_x_q[ORIGIN_W-1]}}, origin_x_q};
	assign origin_y_ext = {{(COORD_W-ORIGIN_W){origin_y_q[ORIGIN_W-1]}}, origin_y_q};

	// 6 and 8 scales by shift and add
	assign advance   = COORD_W'({scale_q, 2'b00}) + COORD_W'({scale_q, 1'b0});
	assign line_step = COORD_W'({scale_q, 3'b000});

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= scale_of(8'd14);
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FONT_SIZE: scale_q    <= scale_of(cfg_data[FONT_W-1:0]);
				REG_ORIGIN_X:  origin_x_q <= cfg_data[ORIGIN_W-1:0];
				REG_ORIGIN_Y:  origin_y_q <= cfg_data[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Cursor and block count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			count_q    <= '0;
		end else if (in_xfer) begin
			if (action == ACT_START) begin
				cursor_x_q <= origin_x_ext;
				cursor_y_q <= origin_y_ext;
				count_q    <= '0;
			end else if (char_code == CODE_NEWLINE) begin
				cursor_x_q <= origin_x_ext;
				cursor_y_q <= cursor_y_q + line_step;
			end else if (!sel.hit) begin
				cursor_x_q <= cursor_x_q + advance;
			end
		end else begin
			if (evt.emit) begin
				count_q <= count_q + QUAD_COUNT_BITS'(1);
			end
			if (evt.done) begin
				cursor_x_q <= cursor_x_q + advance;
			end
		end
	end

	btq_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (scan_load),
		.glyph     (glyph_bits(sel.idx)),
		.cursor_x  (cursor_x_q),
		.cursor_y  (cursor_y_q),
		.scale     (scale_q),
		.count     (count_q),
		.slot_free (slot_free),
		.evt       (evt),
		.quad      (scan_quad)
	);

	btq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (evt.emit),
		.quad_in   (scan_quad),
		.slot_free (slot_free),
		.valid     (out_valid),
		.ready     (out_ready),
		.quad_out  (out_quad)
	);

	assign left_px      = out_quad.left_px;
	assign top_px       = out_quad.top_px;
	assign right_px     = out_quad.right_px;
	assign bottom_px    = out_quad.bottom_px;
	assign quad_number  = out_quad.quad_number;
	assign last_of_char = out_quad.last_of_char;

	// A block is only produced into a free output slot
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		evt.emit |-> (!out_valid || out_ready))
		else $error("block emitted into an occupied output register");

	// An emitted block shows up at the output with the count it was given
	a_emit_number: assert property (@(posedge clk) disable iff (!arst_n)
		evt.emit |=> (out_valid && quad_number == QUAD_NUMBER_W'($past(count_q))))
		else $error("emitted block missing or misnumbered");

	// A glyph load starts the scan and blocks the input
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scan_load |=> (evt.busy && !in_ready))
		else $error("scan did not start after glyph transfer");

	// Completion frees the input channel
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |=> in_ready)
		else $error("input not ready after scan completion");

endmodule

`default_nettype wire

/* test/btq_quad_checker.sv */
// ----------------------------------------------------------------------------
// btq_quad_checker
// Watches the channels of the bitmap text quad generator, predicts the quads
// of every character and compares them in order against the output.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the font registers, pen position and
// quad count, and queues the expected quads at each input transfer. Each
// output transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module btq_quad_checker
	import btq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        action,
	input  logic [15:0]                 char_code,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic signed [COORD_W-1:0]   left_px,
	input  logic signed [COORD_W-1:0]   top_px,
	input  logic signed [COORD_W-1:0]   right_px,
	input  logic signed [COORD_W-1:0]   bottom_px,
	input  logic [QUAD_NUMBER_W-1:0]    quad_number,
	input  logic                        last_of_char,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output int                          fail_count,
	output int                          quads_pending,
	output int                          quads_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAR_ADVANCE = 6;   // pen step after a glyph or blank, in scales
	localparam int LINE_ADVANCE = 8;   // line pitch, in scales

	// Predicted state
	logic [FONT_W-1:0]          font_sz;
	logic [ORIGIN_W-1:0]        org_x;
	logic [ORIGIN_W-1:0]        org_y;
	logic [COORD_W-1:0]         pen_x;
	logic [COORD_W-1:0]         pen_y;
	logic [QUAD_COUNT_BITS-1:0] quad_cnt;

	quad_t quad_expect_q[$];

	// 5x7 font, row 0 in the top bits, leftmost column first
	logic [GLYPH_BITS-1:0] font_rom [0:35];

	initial begin
		font_rom[0]  = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
		font_rom[1]  = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
		font_rom[2]  = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
		font_rom[3]  = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
		font_rom[4]  = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
		font_rom[5]  = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
		font_rom[6]  = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
		font_rom[7]  = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
		font_rom[8]  = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
		font_rom[9]  = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
		font_rom[10] = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
		font_rom[11] = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
		font_rom[12] = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
		font_rom[13] = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
		font_rom[14] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
		font_rom[15] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
		font_rom[16] = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
		font_rom[17] = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
		font_rom[18] = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
		font_rom[19] = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
		font_rom[20] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
		font_rom[21] = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
		font_rom[22] = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
		font_rom[23] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
		font_rom[24] = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
		font_rom[25] = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
		font_rom[26] = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
		font_rom[27] = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
		font_rom[28] = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
		font_rom[29] = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
		font_rom[30] = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
		font_rom[31] = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
		font_rom[32] = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
		font_rom[33] = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
		font_rom[34] = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
		font_rom[35] = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
	end

	// Block size in pixels; small fonts still get one pixel
	function automatic logic [COORD_W-1:0] pixel_scale(input logic [FONT_W-1:0] fs);
		logic [COORD_W-1:0] s;
		s = COORD_W'(fs / 8'd7);
		return (s == '0) ? COORD_W'(1) : s;
	endfunction

	// Origin registers are 14-bit signed; the pen is 16 bits
	function automatic logic [COORD_W-1:0] widen(input logic [ORIGIN_W-1:0] v);
		return {{(COORD_W - ORIGIN_W){v[ORIGIN_W-1]}}, v};
	endfunction

	// Font slot of a code, -1 when it has no glyph
	function automatic int glyph_slot(input logic [15:0] code);
		logic [15:0] up;
		up = (code >= CODE_LOWER_A && code <= CODE_LOWER_Z) ? code - CASE_OFFSET : code;
		if (up >= CODE_UPPER_A && up <= CODE_UPPER_Z)
			return int'(up - CODE_UPPER_A);
		if (up >= CODE_DIGIT_0 && up <= CODE_DIGIT_9)
			return int'(up - CODE_DIGIT_0) + int'(DIGIT_BASE);
		return -1;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FONT_SIZE: font_sz = data[FONT_W-1:0];
			REG_ORIGIN_X:  org_x = data[ORIGIN_W-1:0];
			REG_ORIGIN_Y:  org_y = data[ORIGIN_W-1:0];
			default: ;     // spare index, write dropped
		endcase
	endfunction

	// Queue the quads of one input transfer and move the pen
	function automatic void render_item(input logic act, input logic [15:0] code);
		logic [COORD_W-1:0] sc;
		logic [GLYPH_BITS-1:0] bits;
		quad_t q;
		int slot;
		int lit;
		int k;
		sc = pixel_scale(font_sz);
		slot = glyph_slot(code);
		if (act == ACT_START) begin
			pen_x = widen(org_x);
			pen_y = widen(org_y);
			quad_cnt = '0;
		end else if (code == CODE_NEWLINE) begin
			pen_x = widen(org_x);
			pen_y = COORD_W'(pen_y + LINE_ADVANCE * sc);
		end else begin
			if (slot >= 0) begin
				bits = font_rom[slot];
				lit = $countones(bits);
				k = 0;
				for (int r = 0; r < GLYPH_ROWS; r++) begin
					for (int c = 0; c < GLYPH_COLS; c++) begin
						if (bits[GLYPH_BITS - 1 - (r * GLYPH_COLS + c)]) begin
							q.left_px = COORD_W'(pen_x + c * sc);
							q.top_px = COORD_W'(pen_y + r * sc);
							q.right_px = COORD_W'(q.left_px + sc);
							q.bottom_px = COORD_W'(q.top_px + sc);
							q.quad_number = quad_cnt[QUAD_NUMBER_W-1:0];
							q.last_of_char = (k == lit - 1);
							quad_expect_q.insert(quad_expect_q.size(), q);
							quad_cnt = quad_cnt + QUAD_COUNT_BITS'(1);
							k++;
						end
					end
				end
			end
			// glyph, space and unknown codes all advance the pen
			pen_x = COORD_W'(pen_x + CHAR_ADVANCE * sc);
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_quad();
		quad_t want;
		if (quad_expect_q.size() == 0) begin
			$error("quad transfer with nothing expected: left_px %0d top_px %0d quad_number %0d",
				left_px, top_px, quad_number);
			fail_count++;
		end else begin
			want = quad_expect_q.pop_front();
			check_field("left_px", want.left_px, left_px);
			check_field("top_px", want.top_px, top_px);
			check_field("right_px", want.right_px, right_px);
			check_field("bottom_px", want.bottom_px, bottom_px);
			check_field("quad_number", want.quad_number, quad_number);
			check_field("last_of_char", want.last_of_char, last_of_char);
			quads_checked++;
		end
	endfunction

	// Transfers are taken at the rising edge; inputs first, then outputs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_sz = FONT_W'(14);
			org_x = '0;
			org_y = '0;
			pen_x = '0;
			pen_y = '0;
			quad_cnt = '0;
			quad_expect_q.delete();
			fail_count = 0;
			quads_pending = 0;
			quads_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				render_item(action, char_code);
			if (out_valid && out_ready)
				check_quad();
			quads_pending = quad_expect_q.size();
		end
	end

endmodule

/* test/tb_bitmap_text_quad_generator.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_text_quad_generator
// Stimulus and verdict for the bitmap text quad generator.
// ----------------------------------------------------------------------------
// A directed pass covers code boundaries, case folding, blanks, newline,
// start and origin writes; then a backpressure phase, a long line that
// wraps the pen past the 16-bit limit, and random text under several font
// and origin settings. Both sides idle at random; btq_quad_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_bitmap_text_quad_generator
	import btq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [15:0] CODE_SPACE = 16'h0020;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic [15:0] char_code;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] left_px;
	logic signed [COORD_W-1:0] top_px;
	logic signed [COORD_W-1:0] right_px;
	logic signed [COORD_W-1:0] bottom_px;
	logic [QUAD_NUMBER_W-1:0] quad_number;
	logic last_of_char;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int quads_pending;
	int quads_checked;

	int cycle_count = 0;
	int items_sent = 0;
	int reg_writes = 0;
	int rx_hold_req = 0;
	bit tx_idle_on = 1'b1;
	bit rx_stall_on = 1'b1;

	bitmap_text_quad_generator u_dut (.*);
	btq_quad_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_bitmap_text_quad_generator: done, errors");
			$finish;
		end
	end

	// One input transfer, after a random gap with valid low while sender idling is on
	task automatic send_item(input logic act, input logic [15:0] code);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		char_code <= code;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Drop valid, wait for every expected quad, then let the scan finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (quads_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_glyph_code();
		case ($urandom_range(0, 2))
			0: return CODE_UPPER_A + 16'($urandom_range(0, 25));
			1: return CODE_LOWER_A + 16'($urandom_range(0, 25));
			default: return CODE_DIGIT_0 + 16'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [ORIGIN_W-1:0] pick_origin();
		case ($urandom_range(0, 4))
			0: return ORIGIN_W'(-8192);
			1: return ORIGIN_W'(8191);
			2: return ORIGIN_W'(-1);
			3: return '0;
			default: return ORIGIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [FONT_W-1:0] phase_font(input int k);
		case (k)
			0: return FONT_W'(6);
			1: return FONT_W'(7);
			3: return FONT_W'(13);
			default: return FONT_W'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : rx_side
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				n = rx_stall_on ? $urandom_range(0, 9) : 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int k;
		int i;
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_START;
		char_code = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: code boundaries and folding at the reset font
		send_item(ACT_START, 16'hFFFF);
		send_item(ACT_CHAR, CODE_UPPER_A);
		send_item(ACT_CHAR, CODE_UPPER_Z);
		send_item(ACT_CHAR, CODE_LOWER_A);
		send_item(ACT_CHAR, CODE_LOWER_Z);
		send_item(ACT_CHAR, CODE_DIGIT_0);
		send_item(ACT_CHAR, CODE_DIGIT_9);
		send_item(ACT_CHAR, CODE_UPPER_A - 16'd1);
		send_item(ACT_CHAR, CODE_UPPER_Z + 16'd1);
		send_item(ACT_CHAR, CODE_LOWER_A - 16'd1);
		send_item(ACT_CHAR, CODE_LOWER_Z + 16'd1);
		send_item(ACT_CHAR, CODE_DIGIT_0 - 16'd1);
		send_item(ACT_CHAR, CODE_DIGIT_9 + 16'd1);
		send_item(ACT_CHAR, CODE_SPACE);
		send_item(ACT_CHAR, CODE_NEWLINE);
		send_item(ACT_CHAR, 16'hFFFF);
		send_item(ACT_CHAR, 16'h0000);
		send_item(ACT_CHAR, CODE_LOWER_A + 16'h0100);   // not folded

		// Font 0 gives scale 1; origin moves only at newline or start
		settle();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		write_reg(REG_FONT_SIZE, {6'h2A, 8'h00});
		write_reg(REG_ORIGIN_X, ORIGIN_W'(-8192));
		write_reg(REG_ORIGIN_Y, ORIGIN_W'(8191));
		send_item(ACT_CHAR, CODE_UPPER_A + 16'd22);
		send_item(ACT_CHAR, CODE_NEWLINE);
		send_item(ACT_START, 16'h5A5A);
		send_item(ACT_CHAR, CODE_UPPER_A + 16'd12);

		// Backpressure: receiver holds off while the sender keeps offering
		settle();
		tx_idle_on = 1'b0;
		write_reg(REG_FONT_SIZE, CFG_DATA_W'(20));
		write_reg(REG_ORIGIN_X, '0);
		write_reg(REG_ORIGIN_Y, '0);
		send_item(ACT_START, '0);
		rx_hold_req = LONG_HOLD;
		send_item(ACT_CHAR, CODE_UPPER_A + 16'd1);
		send_item(ACT_CHAR, CODE_DIGIT_0 + 16'd8);
		send_item(ACT_CHAR, CODE_UPPER_A + 16'd22);
		send_item(ACT_CHAR, CODE_UPPER_A + 16'd12);
		send_item(ACT_CHAR, CODE_DIGIT_0);

		// Long line at the largest scale: the pen passes 32767 and wraps
		settle();
		write_reg(REG_FONT_SIZE, {6'h3F, 8'hFF});
		write_reg(REG_ORIGIN_X, ORIGIN_W'(8191));
		write_reg(REG_ORIGIN_Y, ORIGIN_W'(8191));
		send_item(ACT_START, 16'($urandom));
		for (i = 0; i < 118; i++) begin
			if ($urandom_range(0, 99) < 75)
				send_item(ACT_CHAR, CODE_SPACE);
			else
				send_item(ACT_CHAR, pick_glyph_code());
		end

		// Random text under varied settings and idling
		for (k = 0; k < 5; k++) begin
			settle();
			tx_idle_on = (k % 3) != 0;
			rx_stall_on = (k % 4) != 1;
			write_reg(REG_FONT_SIZE, {6'($urandom), phase_font(k)});
			write_reg(REG_ORIGIN_X, pick_origin());
			write_reg(REG_ORIGIN_Y, pick_origin());
			send_item(ACT_START, 16'($urandom));
			for (i = 0; i < 12; i++) begin
				r = $urandom_range(0, 99);
				if (r < 64)
					send_item(ACT_CHAR, pick_glyph_code());
				else if (r < 76)
					send_item(ACT_CHAR, CODE_SPACE);
				else if (r < 85)
					send_item(ACT_CHAR, CODE_NEWLINE);
				else if (r < 94)
					send_item(ACT_CHAR, 16'($urandom));
				else
					send_item(ACT_START, 16'($urandom));
			end
		end

		settle();
		$display("covered %0d characters and starts, %0d register writes, %0d quads compared",
			items_sent, reg_writes, quads_checked);
		$display("scales 1 to 36, origin extremes, pen wrap and a long output hold-off");
		if (fail_count == 0 && quads_pending == 0) begin
			$display("tb_bitmap_text_quad_generator: done, clean");
		end else begin
			$display("tb_bitmap_text_quad_generator: done, errors");
		end
		$finish;
	end

endmodule
